>>> hw/rtl/krt_pkg.sv
// krt_pkg: shared types for the keyed record table
// request codes, state enum, token control struct and result record
// no dependencies
package krt_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 64;

    localparam int KEY_W       = 16;
    localparam int ENTRY_W     = 64;
    localparam int SLOT_OUT_W  = 4;
    localparam int HELD_OUT_W  = 5;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_REMOVE = 2'd3
    } req_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    // control part of the request token that walks the cell row
    typedef struct packed {
        logic              vld;
        req_t              op;
        logic              found;
        logic [KEY_W-1:0]  key;
    } tok_ctl_t;

    typedef struct packed {
        logic                  done_ok;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [ENTRY_W-1:0]    entry_out;
        logic [HELD_OUT_W-1:0] entries_held;
    } result_t;

endpackage

>>> hw/rtl/krt_cell.sv
// krt_cell: one table slot plus one stage of the request token pipeline
// holds a key and payload; acts on the token passing through it
// depends on krt_pkg
module krt_cell #(
    parameter int CAPACITY     = krt_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = krt_pkg::PAYLOAD_BITS_DEF,
    parameter int INDEX        = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [$clog2(CAPACITY+1)-1:0]         count,
    input  krt_pkg::tok_ctl_t                     tok_ctl_i,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] tok_idx_i,
    input  logic [PAYLOAD_BITS-1:0]               tok_pay_i,
    input  logic [krt_pkg::KEY_W-1:0]             nbr_key,
    input  logic [PAYLOAD_BITS-1:0]               nbr_pay,
    output krt_pkg::tok_ctl_t                     tok_ctl_o,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] tok_idx_o,
    output logic [PAYLOAD_BITS-1:0]               tok_pay_o,
    output logic [krt_pkg::KEY_W-1:0]             key_o,
    output logic [PAYLOAD_BITS-1:0]               pay_o
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY+1);

    logic [krt_pkg::KEY_W-1:0] key_reg, key_next;
    logic [PAYLOAD_BITS-1:0]   pay_reg, pay_next;
    krt_pkg::tok_ctl_t         ctl_reg, ctl_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [PAYLOAD_BITS-1:0]   tpay_reg, tpay_next;

    logic [CNT_W-1:0] here;
    logic             live;
    logic             hit;
    logic             add_here;
    logic             shift;

    assign here = CNT_W'(INDEX);
    assign live = (here < count);

    always_comb
    begin
        hit      = tok_ctl_i.vld && !tok_ctl_i.found && (tok_ctl_i.op != krt_pkg::REQ_ADD)
                   && live && (key_reg == tok_ctl_i.key);
        add_here = tok_ctl_i.vld && (tok_ctl_i.op == krt_pkg::REQ_ADD) && (here == count);
        // removal at or before this slot: pull the neighbor down
        shift    = tok_ctl_i.vld && (tok_ctl_i.op == krt_pkg::REQ_REMOVE)
                   && (tok_ctl_i.found || hit);

        ctl_next       = tok_ctl_i;
        ctl_next.found = tok_ctl_i.found | hit | add_here;
        idx_next       = (hit || add_here) ? IDX_W'(INDEX) : tok_idx_i;
        tpay_next      = (hit && (tok_ctl_i.op == krt_pkg::REQ_LOOKUP)) ? pay_reg : tok_pay_i;

        key_next = key_reg;
        pay_next = pay_reg;
        if (add_here)
        begin
            key_next = tok_ctl_i.key;
            pay_next = tok_pay_i;
        end
        else if (hit && (tok_ctl_i.op == krt_pkg::REQ_UPDATE))
        begin
            pay_next = tok_pay_i;
        end
        else if (shift)
        begin
            key_next = nbr_key;
            pay_next = nbr_pay;
        end
    end

    // slot storage and token index and payload registers, undefined until written
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        pay_reg  <= pay_next;
        idx_reg  <= idx_next;
        tpay_reg <= tpay_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign tok_ctl_o = ctl_reg;
    assign tok_idx_o = idx_reg;
    assign tok_pay_o = tpay_reg;
    assign key_o     = key_reg;
    assign pay_o     = pay_reg;

endmodule

>>> hw/rtl/keyed_record_table_core.sv
// keyed_record_table_core: top level of the keyed record table
// a row of krt_cell slots walked by one request token, count and result buffer
// depends on krt_pkg and krt_cell
//
//  channel   | signals                                          | direction
//  ----------+--------------------------------------------------+----------
//  request   | in_valid, in_ready, req_type, key, entry_in      | in
//  result    | out_valid, out_ready, done_ok, slot_index,        | out
//            | entry_out, entries_held                          |
//
//  the request token visits one cell per cycle along the row of CAPACITY
//  cells and its result is then registered in the output register or skid entry
//  one request is in the row at a time; the next can be taken once the token has
//  left the last cell and the state is back to idle, if the skid entry is free
//  reset clears the entry count and the token valid bits; slot contents are
//  left as they are and only slots below the count are ever looked at
//  a stalled result waits in the output register, a second one in a skid entry;
//  a new request is taken while only the output register is occupied
module keyed_record_table_core #(
    parameter int CAPACITY     = krt_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = krt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        req_type,
    input  logic [krt_pkg::KEY_W-1:0]         key,
    input  logic [krt_pkg::ENTRY_W-1:0]       entry_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              done_ok,
    output logic [krt_pkg::SLOT_OUT_W-1:0]    slot_index,
    output logic [krt_pkg::ENTRY_W-1:0]       entry_out,
    output logic [krt_pkg::HELD_OUT_W-1:0]    entries_held
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY+1);

    // token bus between cells: position 0 is the launch, CAPACITY the exit
    krt_pkg::tok_ctl_t       tok_ctl [0:CAPACITY];
    logic [IDX_W-1:0]        tok_idx [0:CAPACITY];
    logic [PAYLOAD_BITS-1:0] tok_pay [0:CAPACITY];
    logic [CAPACITY:0]       tok_vld;

    logic [krt_pkg::KEY_W-1:0] slot_key [0:CAPACITY-1];
    logic [PAYLOAD_BITS-1:0]   slot_pay [0:CAPACITY-1];

    krt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic              out_vld_reg, out_vld_next;
    krt_pkg::result_t  out_reg, out_next;
    logic              skid_vld_reg, skid_vld_next;
    krt_pkg::result_t  skid_reg, skid_next;

    logic              in_xfer;
    logic              tok_exit;
    krt_pkg::result_t  res_new;
    logic [IDX_W+krt_pkg::SLOT_OUT_W-1:0] slot_wide;
    logic [CNT_W+krt_pkg::HELD_OUT_W-1:0] held_wide;

    assign in_xfer  = in_valid && in_ready;
    assign tok_exit = tok_ctl[CAPACITY].vld;

    // launch the token straight into cell 0
    always_comb
    begin
        tok_ctl[0].vld   = in_xfer;
        tok_ctl[0].op    = krt_pkg::req_t'(req_type);
        tok_ctl[0].found = 1'b0;
        tok_ctl[0].key   = key;
        tok_idx[0]       = '0;
        tok_pay[0]       = entry_in[PAYLOAD_BITS-1:0];
    end

    assign tok_vld[0] = tok_ctl[0].vld;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [krt_pkg::KEY_W-1:0] nbr_key;
        logic [PAYLOAD_BITS-1:0]   nbr_pay;

        if (i + 1 < CAPACITY)
        begin : g_nbr
            assign nbr_key = slot_key[i+1];
            assign nbr_pay = slot_pay[i+1];
        end
        else
        begin : g_last
            // last slot drops out of range on a remove, contents do not matter
            assign nbr_key = slot_key[i];
            assign nbr_pay = slot_pay[i];
        end

        krt_cell #(
            .CAPACITY     (CAPACITY),
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .INDEX        (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .count     (count_reg),
            .tok_ctl_i (tok_ctl[i]),
            .tok_idx_i (tok_idx[i]),
            .tok_pay_i (tok_pay[i]),
            .nbr_key   (nbr_key),
            .nbr_pay   (nbr_pay),
            .tok_ctl_o (tok_ctl[i+1]),
            .tok_idx_o (tok_idx[i+1]),
            .tok_pay_o (tok_pay[i+1]),
            .key_o     (slot_key[i]),
            .pay_o     (slot_pay[i])
        );

        assign tok_vld[i+1] = tok_ctl[i+1].vld;
    end

    // result of the token leaving the last cell
    always_comb
    begin
        count_next = count_reg;
        if (tok_exit && tok_ctl[CAPACITY].found)
        begin
            case (tok_ctl[CAPACITY].op)
                krt_pkg::REQ_ADD:    count_next = count_reg + CNT_W'(1);
                krt_pkg::REQ_REMOVE: count_next = count_reg - CNT_W'(1);
                default:             count_next = count_reg;
            endcase
        end

        slot_wide = {{krt_pkg::SLOT_OUT_W{1'b0}}, tok_idx[CAPACITY]};
        held_wide = {{krt_pkg::HELD_OUT_W{1'b0}}, count_next};

        res_new.done_ok      = tok_ctl[CAPACITY].found;
        res_new.slot_index   = tok_ctl[CAPACITY].found
                               ? slot_wide[krt_pkg::SLOT_OUT_W-1:0] : '0;
        res_new.entry_out    = (tok_ctl[CAPACITY].found
                                && (tok_ctl[CAPACITY].op == krt_pkg::REQ_LOOKUP))
                               ? krt_pkg::ENTRY_W'(tok_pay[CAPACITY]) : '0;
        res_new.entries_held = held_wide[krt_pkg::HELD_OUT_W-1:0];
    end

    // output register with one skid entry
    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        skid_vld_next = skid_vld_reg;
        skid_next     = skid_reg;
        if (!out_vld_reg || out_ready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_next  = 1'b1;
                out_next      = skid_reg;
                skid_vld_next = tok_exit;
                skid_next     = res_new;
            end
            else
            begin
                out_vld_next = tok_exit;
                out_next     = res_new;
            end
        end
        else if (tok_exit)
        begin
            skid_vld_next = 1'b1;
            skid_next     = res_new;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            krt_pkg::ST_IDLE: if (in_xfer) state_next = krt_pkg::ST_WALK;
            krt_pkg::ST_WALK: if (tok_exit) state_next = krt_pkg::ST_IDLE;
            default:          state_next = krt_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        case (state_reg)
            krt_pkg::ST_IDLE: in_ready = !skid_vld_reg;
            krt_pkg::ST_WALK: in_ready = 1'b0;
            default:          in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= krt_pkg::ST_IDLE;
            count_reg    <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_vld_reg;
    assign done_ok      = out_reg.done_ok;
    assign slot_index   = out_reg.slot_index;
    assign entry_out    = out_reg.entry_out;
    assign entries_held = out_reg.entries_held;

`ifndef SYNTHESIS
    // at most one token anywhere in the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one request token in the cell row");

    // a token leaves the row only during a walk
    a_exit_walk: assert property (@(posedge clk) disable iff (!rst_n)
        tok_exit |-> (state_reg == krt_pkg::ST_WALK))
        else $error("token left the row outside a walk");

    // the skid entry is always free when a result arrives
    a_skid_free: assert property (@(posedge clk) disable iff (!rst_n)
        tok_exit |-> !skid_vld_reg)
        else $error("result arrived with skid entry occupied");

    // count stays within the table size
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // count only moves when a token leaves the row
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tok_exit |=> $stable(count_reg))
        else $error("entry count changed without a finished request");
`endif

endmodule
